// File: rtl/core/hs_pkg.sv
package hs_pkg;

  // default width of the length field carried in the padding
  localparam int unsigned LengthBitsDef = 64;

  localparam logic [7:0]  IpadByte   = 8'h36;
  localparam logic [7:0]  OpadByte   = 8'h5c;
  localparam logic [7:0]  PadHead    = 8'h80;
  localparam logic [31:0] IpadWord   = {4{IpadByte}};
  localparam logic [31:0] OpadWord   = {4{OpadByte}};
  // outer hash length: 64-byte pad block plus 32-byte inner digest, in bits
  localparam logic [31:0] OuterLenBits = 32'd768;

  localparam logic [31:0] HashIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // input item kinds
  typedef enum logic [1:0] {
    KindKey = 2'd0,
    KindMsg = 2'd1,
    KindFin = 2'd2
  } kind_e;

  // block source for one compression
  typedef enum logic [2:0] {
    SrcKeyRaw  = 3'd0,
    SrcKeyIpad = 3'd1,
    SrcKeyOpad = 3'd2,
    SrcBuf     = 3'd3,
    SrcInner   = 3'd4
  } src_e;

  // byte written into the block buffer
  typedef enum logic [1:0] {
    BufByte = 2'd0,
    BufHead = 2'd1,
    BufZero = 2'd2,
    BufLen  = 2'd3
  } buf_sel_e;

  typedef struct packed {
    logic       byte_ld;
    logic       key_wr;
    logic       key_clr;
    logic       key_from_h;
    logic       inner_from_h;
    logic       buf_wr;
    buf_sel_e   buf_sel;
    logic [5:0] buf_addr;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       cnt_set64;
    logic       cmp_start;
    logic       cmp_iv;
    src_e       cmp_src;
    logic [2:0] out_idx;
  } hs_cmd_t;

  typedef struct packed {
    logic       cmp_done;
    logic       cmp_busy;
    logic [5:0] cnt_lo;
  } hs_sts_t;

endpackage

// File: rtl/core/hs_dpath.sv
module hs_dpath #(
  parameter int unsigned LengthBits = hs_pkg::LengthBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hs_pkg::hs_cmd_t cmd_i,
  input  logic [7:0]      byte_i,
  output hs_pkg::hs_sts_t sts_o,
  output logic [31:0]     digest_o
);
  import hs_pkg::*;

  localparam int unsigned CntW = LengthBits - 3;

  logic [7:0]      byte_q;
  logic [31:0]     key_q [16];
  logic [31:0]     buf_q [16];
  logic [31:0]     inner_q [8];
  logic [31:0]     h_q [8];
  logic [31:0]     v_q [8];
  logic [31:0]     w_q [16];
  logic [5:0]      rnd_q;
  logic            busy_q, fin_q, done_q;
  logic [CntW-1:0] cnt_q;
  src_e            src_q;

  logic [31:0]     src_word, w_t, t1, t2;
  logic [31:0]     key_w, buf_w;
  logic [7:0]      len_byte, wr_byte;
  logic [LengthBits-1:0] len_bits;
  logic [63:0]     len64;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // block word for the current round
  assign key_w = key_q[rnd_q[3:0]];
  assign buf_w = buf_q[rnd_q[3:0]];

  always_comb begin
    case (src_q)
      SrcKeyRaw:  src_word = key_w;
      SrcKeyIpad: src_word = key_w ^ IpadWord;
      SrcKeyOpad: src_word = key_w ^ OpadWord;
      SrcBuf:     src_word = buf_w;
      SrcInner: begin
        if (!rnd_q[3])             src_word = inner_q[rnd_q[2:0]];
        else if (rnd_q[3:0] == 4'd8)  src_word = {PadHead, 24'h0};
        else if (rnd_q[3:0] == 4'd15) src_word = OuterLenBits;
        else                       src_word = '0;
      end
      default:    src_word = '0;
    endcase
  end

  // message schedule and round function
  assign w_t = (rnd_q[5:4] == 2'b00) ? src_word :
               w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_t;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // padding length byte, most significant first
  assign len_bits = {cnt_q, 3'b000};
  assign len64    = 64'(len_bits);
  assign len_byte = len64[{~cmd_i.buf_addr[2:0], 3'b000} +: 8];

  always_comb begin
    case (cmd_i.buf_sel)
      BufByte: wr_byte = byte_q;
      BufHead: wr_byte = PadHead;
      BufZero: wr_byte = '0;
      BufLen:  wr_byte = len_byte;
      default: wr_byte = '0;
    endcase
  end

  // round sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
      src_q  <= SrcKeyRaw;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (cmd_i.cmp_start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
        src_q  <= cmd_i.cmp_src;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // working variables, schedule window, chaining value
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_start) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= cmd_i.cmp_iv ? HashIv[i] : h_q[i];
        if (cmd_i.cmp_iv) h_q[i] <= HashIv[i];
      end
    end else if (busy_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_t;
    end else if (fin_q) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  // padded key store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) key_q[i] <= '0;
    end else if (cmd_i.key_clr) begin
      for (int i = 0; i < 16; i++) key_q[i] <= '0;
    end else if (cmd_i.key_from_h) begin
      for (int i = 0; i < 16; i++) key_q[i] <= (i < 8) ? h_q[i % 8] : '0;
    end else if (cmd_i.key_wr) begin
      key_q[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] <= byte_q;
    end
  end

  // block buffer, inner digest, input byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_ld) byte_q <= byte_i;
    if (cmd_i.buf_wr) begin
      buf_q[cmd_i.buf_addr[5:2]][{~cmd_i.buf_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (cmd_i.inner_from_h) begin
      for (int i = 0; i < 8; i++) inner_q[i] <= h_q[i];
    end
  end

  // byte counter of the running hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_set64) begin
      cnt_q <= CntW'(64);
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  assign sts_o.cmp_done = done_q;
  assign sts_o.cmp_busy = busy_q;
  assign sts_o.cnt_lo   = cnt_q[5:0];
  assign digest_o       = h_q[cmd_i.out_idx];

endmodule

// File: rtl/core/hs_ctrl.sv
module hs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic [1:0]      s_kind_i,
  input  logic            s_last_i,
  output logic            s_ready_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic            m_last_o,
  output hs_pkg::hs_cmd_t cmd_o,
  input  hs_pkg::hs_sts_t sts_i
);
  import hs_pkg::*;

  typedef enum logic [13:0] {
    StIdle = 14'b00000000000001,
    StDisp = 14'b00000000000010,
    StKraw = 14'b00000000000100,
    StKbuf = 14'b00000000001000,
    StEndk = 14'b00000000010000,
    StPad  = 14'b00000000100000,
    StPadc = 14'b00000001000000,
    StPadf = 14'b00000010000000,
    StIpad = 14'b00000100000000,
    StMbyt = 14'b00001000000000,
    StMbuf = 14'b00010000000000,
    StFin  = 14'b00100000000000,
    StOpad = 14'b01000000000000,
    StOinn = 14'b10000000000000
  } state_e;

  typedef enum logic [2:0] {
    PhAwait = 3'b001,
    PhKey   = 3'b010,
    PhMsg   = 3'b100
  } phase_e;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] kind_q, kind_d;
  logic       last_q, last_d;
  logic       ge64_q, ge64_d;
  logic       long_q, long_d;
  logic       close_key_q, close_key_d;
  logic       two_blk_q, two_blk_d;
  logic [6:0] ptr_q, ptr_d;
  logic [2:0] idx_q, idx_d;
  logic       out_q, out_d;
  logic       done;

  assign done = sts_i.cmp_done;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    kind_d      = kind_q;
    last_d      = last_q;
    ge64_d      = ge64_q;
    long_d      = long_q;
    close_key_d = close_key_q;
    two_blk_d   = two_blk_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    out_d       = out_q;
    cmd_o          = '0;
    cmd_o.buf_sel  = BufByte;
    cmd_o.cmp_src  = SrcBuf;
    cmd_o.buf_addr = sts_i.cnt_lo;
    cmd_o.out_idx  = idx_q;

    // result words go out while the hash engine is quiet
    if (out_q) begin
      if (m_ready_i) begin
        idx_d = idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          out_d         = 1'b0;
          cmd_o.key_clr = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          ge64_d        = 1'b0;
          long_d        = 1'b0;
          phase_d       = PhAwait;
          state_d       = StIdle;
        end
      end
    end else begin
      case (state_q)
        StIdle: begin
          if (s_valid_i) begin
            cmd_o.byte_ld = 1'b1;
            kind_d  = s_kind_i;
            last_d  = s_last_i;
            state_d = StDisp;
          end
        end
        StDisp: begin
          case (kind_q)
            KindKey: begin
              if (phase_q == PhMsg) begin
                state_d = StIdle;
              end else begin
                phase_d = PhKey;
                if (!ge64_q) begin
                  cmd_o.key_wr  = 1'b1;
                  cmd_o.cnt_inc = 1'b1;
                  if (sts_i.cnt_lo == 6'd63) ge64_d = 1'b1;
                  state_d = last_q ? StEndk : StIdle;
                end else if (!long_q) begin
                  // first byte past 64: hash the stored key block
                  long_d          = 1'b1;
                  cmd_o.buf_wr    = 1'b1;
                  cmd_o.cnt_inc   = 1'b1;
                  cmd_o.cmp_start = 1'b1;
                  cmd_o.cmp_iv    = 1'b1;
                  cmd_o.cmp_src   = SrcKeyRaw;
                  state_d         = StKraw;
                end else begin
                  cmd_o.buf_wr  = 1'b1;
                  cmd_o.cnt_inc = 1'b1;
                  if (sts_i.cnt_lo == 6'd63) begin
                    cmd_o.cmp_start = 1'b1;
                    state_d         = StKbuf;
                  end else begin
                    state_d = last_q ? StEndk : StIdle;
                  end
                end
              end
            end
            KindMsg: state_d = (phase_q == PhMsg) ? StMbyt : StEndk;
            KindFin: state_d = (phase_q == PhMsg) ? StFin : StEndk;
            default: state_d = StIdle;
          endcase
        end
        StKraw, StKbuf: begin
          if (done) state_d = last_q ? StEndk : StIdle;
        end
        StEndk: begin
          if (long_q) begin
            close_key_d   = 1'b1;
            cmd_o.buf_wr  = 1'b1;
            cmd_o.buf_sel = BufHead;
            ptr_d         = {1'b0, sts_i.cnt_lo} + 7'd1;
            two_blk_d     = (sts_i.cnt_lo >= 6'd56);
            state_d       = StPad;
          end else begin
            cmd_o.cmp_start = 1'b1;
            cmd_o.cmp_iv    = 1'b1;
            cmd_o.cmp_src   = SrcKeyIpad;
            state_d         = StIpad;
          end
        end
        StFin: begin
          close_key_d   = 1'b0;
          cmd_o.buf_wr  = 1'b1;
          cmd_o.buf_sel = BufHead;
          ptr_d         = {1'b0, sts_i.cnt_lo} + 7'd1;
          two_blk_d     = (sts_i.cnt_lo >= 6'd56);
          state_d       = StPad;
        end
        StPad: begin
          cmd_o.buf_addr = ptr_q[5:0];
          if (ptr_q[6]) begin
            cmd_o.cmp_start = 1'b1;
            ptr_d           = '0;
            two_blk_d       = 1'b0;
            state_d         = two_blk_q ? StPadc : StPadf;
          end else begin
            cmd_o.buf_wr  = 1'b1;
            cmd_o.buf_sel = (two_blk_q || ptr_q < 7'd56) ? BufZero : BufLen;
            ptr_d         = ptr_q + 7'd1;
          end
        end
        StPadc: begin
          if (done) state_d = StPad;
        end
        StPadf: begin
          if (done) begin
            cmd_o.cmp_start = 1'b1;
            cmd_o.cmp_iv    = 1'b1;
            if (close_key_q) begin
              cmd_o.key_from_h = 1'b1;
              cmd_o.cmp_src    = SrcKeyIpad;
              state_d          = StIpad;
            end else begin
              cmd_o.inner_from_h = 1'b1;
              cmd_o.cmp_src      = SrcKeyOpad;
              state_d            = StOpad;
            end
          end
        end
        StIpad: begin
          if (done) begin
            phase_d         = PhMsg;
            cmd_o.cnt_set64 = 1'b1;
            case (kind_q)
              KindMsg: state_d = StMbyt;
              KindFin: state_d = StFin;
              default: state_d = StIdle;
            endcase
          end
        end
        StMbyt: begin
          cmd_o.buf_wr  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          if (sts_i.cnt_lo == 6'd63) begin
            cmd_o.cmp_start = 1'b1;
            state_d         = StMbuf;
          end else begin
            state_d = last_q ? StFin : StIdle;
          end
        end
        StMbuf: begin
          if (done) state_d = last_q ? StFin : StIdle;
        end
        StOpad: begin
          if (done) begin
            cmd_o.cmp_start = 1'b1;
            cmd_o.cmp_src   = SrcInner;
            state_d         = StOinn;
          end
        end
        StOinn: begin
          if (done) begin
            out_d = 1'b1;
            idx_d = '0;
          end
        end
        default: state_d = StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhAwait;
      kind_q      <= KindKey;
      last_q      <= 1'b0;
      ge64_q      <= 1'b0;
      long_q      <= 1'b0;
      close_key_q <= 1'b0;
      two_blk_q   <= 1'b0;
      ptr_q       <= '0;
      idx_q       <= '0;
      out_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      kind_q      <= kind_d;
      last_q      <= last_d;
      ge64_q      <= ge64_d;
      long_q      <= long_d;
      close_key_q <= close_key_d;
      two_blk_q   <= two_blk_d;
      ptr_q       <= ptr_d;
      idx_q       <= idx_d;
      out_q       <= out_d;
    end
  end

  assign s_ready_o = (state_q == StIdle) && !out_q;
  assign m_valid_o = out_q;
  assign m_last_o  = (idx_q == 3'd7);

endmodule

// File: rtl/core/hmac_sha256_engine_unit.sv
// key bytes fill the key store, then the block buffer, and message bytes the block buffer;
// each full 64-byte block is hashed in the shared one-round-per-cycle compression unit
// finish: padding (up to 72 byte writes) plus three to four compressions once the key is closed, then
// eight digest transfers; one item is worked on at a time
// reset: asynchronous, active low; key store cleared, chaining value set on first use
module hmac_sha256_engine_unit #(
  parameter int unsigned LENGTH_BITS = hs_pkg::LengthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast_o
);
  import hs_pkg::*;

  hs_cmd_t     cmd;
  hs_sts_t     sts;
  logic [31:0] digest;

  // control state machine
  hs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_kind_i  (s_axis_tuser_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_last_o  (m_axis_tlast_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // hash datapath
  hs_dpath #(
    .LengthBits (LENGTH_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .byte_i   (s_axis_tdata_i),
    .sts_o    (sts),
    .digest_o (digest)
  );

  assign m_axis_tdata_o = {5'b0, cmd.out_idx, digest};

  // no input transfer while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input accepted during digest output");

  // compression never restarted while running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cmp_start |-> !sts.cmp_busy)
    else $error("compression started while busy");

  // output burst ends after the final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("output continues past last word");

endmodule

// File: sim/tb_hmac_sha256_engine_unit.sv
`timescale 1ns / 1ps

module tb_hmac_sha256_engine_unit;
  import hs_pkg::*;

  localparam int unsigned KindBad = 3;  // not a defined kind, ignored by the block
  localparam int unsigned PhAwait = 0;
  localparam int unsigned PhKey   = 1;
  localparam int unsigned PhMsg   = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } hmac_in_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  hmac_sha256_engine_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // predictor state
  logic [7:0]  pk [64];
  logic [63:0] key_cnt;
  logic [31:0] hv [8];
  logic [7:0]  blkbuf [64];
  logic [63:0] msg_cnt;
  int unsigned ph;

  hmac_in_t    pending_q[$];
  digest_out_t digest_q[$];
  int          n_fail;
  bit          hold_req;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic sha_round_block(input logic [7:0] b [64]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endtask

  task automatic start_padded(input logic [7:0] pad);
    logic [7:0] b [64];
    for (int i = 0; i < 8; i++) hv[i] = HashIv[i];
    for (int i = 0; i < 64; i++) b[i] = pk[i] ^ pad;
    sha_round_block(b);
  endtask

  task automatic absorb_byte(inout logic [63:0] cnt, input logic [7:0] b);
    blkbuf[cnt[5:0]] = b;
    cnt++;
    if (cnt[5:0] == 0) sha_round_block(blkbuf);
  endtask

  task automatic close_hash(input logic [63:0] cnt);
    int unsigned pos;
    logic [63:0] bits;
    pos = cnt[5:0];
    bits = cnt << 3;
    blkbuf[pos++] = PadHead;
    if (pos > 56) begin
      while (pos < 64) blkbuf[pos++] = 8'h00;
      sha_round_block(blkbuf);
      pos = 0;
    end
    while (pos < 56) blkbuf[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) blkbuf[56+i] = bits[63-8*i -: 8];
  sha_round_block(blkbuf);
  endtask

  task automatic close_key();
    if (key_cnt > 64) begin
      close_hash(key_cnt);
      for (int i = 0; i < 64; i++) pk[i] = 8'h00;
      for (int i = 0; i < 8; i++)
        {pk[4*i], pk[4*i+1], pk[4*i+2], pk[4*i+3]} = hv[i];
    end
    start_padded(IpadByte);
    msg_cnt = 64;
    ph = PhMsg;
  endtask

  task automatic clear_session();
    for (int i = 0; i < 64; i++) pk[i] = 8'h00;
    key_cnt = 0;
    for (int i = 0; i < 8; i++) hv[i] = HashIv[i];
    msg_cnt = 0;
    ph = PhAwait;
  endtask

  // inner hash close, outer hash and digest words
  task automatic finish_hmac();
    logic [31:0] inner [8];
    logic [63:0] cnt;
    digest_out_t d;
    close_hash(msg_cnt);
    for (int i = 0; i < 8; i++) inner[i] = hv[i];
    start_padded(OpadByte);
    cnt = 64;
    for (int i = 0; i < 32; i++) absorb_byte(cnt, inner[i/4][31-8*(i%4) -: 8]);
    close_hash(cnt);
    for (int i = 0; i < 8; i++) begin
      d.word = hv[i];
      d.idx  = 3'(i);
      d.last = (i == 7);
      digest_q.push_back(d);
    end
    clear_session();
  endtask

  task automatic predict_hmac(input hmac_in_t it);
    case (it.kind)
      KindKey: begin
        if (ph != PhMsg) begin
          ph = PhKey;
          if (key_cnt < 64) begin
            pk[key_cnt[5:0]] = it.data;
            key_cnt++;
          end else begin
            if (key_cnt == 64) begin
              for (int i = 0; i < 8; i++) hv[i] = HashIv[i];
              sha_round_block(pk);
            end
            absorb_byte(key_cnt, it.data);
          end
          if (it.last) close_key();
        end
      end
      KindMsg: begin
        if (ph != PhMsg) close_key();
        absorb_byte(msg_cnt, it.data);
        if (it.last) finish_hmac();
      end
      KindFin: begin
        if (ph != PhMsg) close_key();
        finish_hmac();
      end
      default: ;
    endcase
  endtask

  task automatic add(input int kind, input int data, input bit last);
    hmac_in_t it;
    it.kind = 2'(kind);
    it.data = 8'(data);
    it.last = last;
    pending_q.push_back(it);
  endtask

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // driver
  int src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= '0;
      s_axis_tlast_i  <= 1'b0;
      src_gap         <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_hmac({s_axis_tuser_i, s_axis_tdata_i, s_axis_tlast_i});
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_gap > 0) begin
          s_axis_tvalid_i <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pending_q.size() > 0) begin
          hmac_in_t it;
          it = pending_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= it.kind;
          s_axis_tdata_i  <= it.data;
          s_axis_tlast_i  <= it.last;
          src_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver stall, counted apart from the monitor
  int hold_cnt;
  bit hold_on;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      hold_on  <= 1'b0;
    end else if (hold_req && hold_cnt < 3000) begin
      hold_cnt <= hold_cnt + 1;
      hold_on  <= 1'b1;
    end else begin
      hold_on  <= 1'b0;
    end
  end

  // monitor and ready control
  int sink_gap;
  digest_out_t got, want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o[31:0], m_axis_tdata_o[34:32], m_axis_tlast_o};
        if (digest_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected digest transfer %h", got);
        end else begin
          want = digest_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display("digest mismatch: exp word %h idx %0d last %0b, got %h %0d %0b",
                       want.word, want.idx, want.last, got.word, got.idx, got.last);
          end
        end
        sink_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        m_axis_tready_i <= 1'b0;
      end else if (hold_on) begin
        m_axis_tready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    n_fail = 0;
    hold_req = 1'b0;
    clear_session();
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short key, short message
    add(KindKey, 8'h00, 0); add(KindKey, 8'hff, 1);
    add(KindMsg, 8'hff, 0); add(KindMsg, 8'h00, 1);
    // no key, finish alone (empty key, empty message)
    add(KindFin, 8'hff, 1);
    // key byte after key end ignored, unknown kind ignored, finish mid-message
    add(KindKey, 8'h5a, 1); add(KindKey, 8'ha5, 0); add(KindBad, 8'h81, 1);
    add(KindMsg, 8'h12, 0); add(KindFin, 8'h00, 0);
    // key in progress ended by a message byte
    add(KindKey, 8'h7e, 0); add(KindMsg, 8'h01, 1);
    // long key, 66 bytes
    for (int i = 0; i < 66; i++) add(KindKey, i, i == 65);
    add(KindMsg, 8'h80, 1);
    // receiver stalls long while the sender keeps going
    hold_req = 1'b1;

    // random sessions until at least 125 items are pending
    while (pending_q.size() < 125) begin
      int klen, mlen;
      klen = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 70) : $urandom_range(0, 8);
      mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 6);
      for (int i = 0; i < klen; i++)
        add(KindKey, $urandom_range(0, 255), (i == klen - 1) && $urandom_range(0, 1));
      if ($urandom_range(0, 5) == 0) add(KindBad, $urandom_range(0, 255), $urandom_range(0, 1));
      for (int i = 0; i < mlen; i++)
        add(KindMsg, $urandom_range(0, 255), i == mlen - 1);
      if (mlen == 0 || $urandom_range(0, 4) == 0)
        add(KindFin, $urandom_range(0, 255), $urandom_range(0, 1));
    end

    wait (pending_q.size() == 0 && !(s_axis_tvalid_i));
    wait (digest_q.size() == 0);
    repeat (500) @(posedge clk_i);
    if (n_fail == 0 && digest_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
